// ----- rtl/mhtq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhtq_pkg
// Shared constants, types and codes for the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int HEAP_DEPTH = 32;
  localparam int ID_COUNT   = 256;
  localparam int TIME_WIDTH = 32;

  localparam int HEAP_AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W   = CNT_W + 1;
  localparam int ID_W    = $clog2(ID_COUNT);

  localparam int ID_FW    = 8;
  localparam int TMO_FW   = 20;
  localparam int DELAY_FW = 20;
  localparam logic [DELAY_FW-1:0] DELAY_MAX = '1;

  typedef logic [TIME_WIDTH-1:0] time_t;

  // request codes
  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_ADJUST = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_TICK   = 2'd3
  } req_e;

  // result codes
  typedef enum logic [1:0] {
    KIND_FIRED   = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_UNKNOWN = 2'd2,
    KIND_FULL    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RM_LAST,
    ST_DN_C,
    ST_DN_C1,
    ST_DN_CMP,
    ST_UP_P,
    ST_PLACE,
    ST_TICK_CHK,
    ST_EMIT,
    ST_OUT
  } state_e;

  // compare/subtract unit results
  typedef struct packed {
    logic  lt;
    time_t diff;
  } alu_res_t;

endpackage

// ----- rtl/mhtq_ram.sv -----
// ----------------------------------------------------------------------------
// mhtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhtq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mhtq_alu.sv -----
// ----------------------------------------------------------------------------
// mhtq_alu
// Shared deadline unit: one subtract giving a - b and the unsigned a < b flag.
// ----------------------------------------------------------------------------
module mhtq_alu (
  input  mhtq_pkg::time_t    a_i,
  input  mhtq_pkg::time_t    b_i,
  output mhtq_pkg::alu_res_t res_o
);
  import mhtq_pkg::*;

  logic [TIME_WIDTH:0] sub;

  // borrow out of the subtract is the less-than flag
  assign sub        = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.lt   = sub[TIME_WIDTH];
  assign res_o.diff = sub[TIME_WIDTH-1:0];

endmodule

// ----- rtl/min_heap_timer_queue.sv -----
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Binary min-heap of timers by deadline with id-to-slot table and ms clock.
// A tick fires due timers one at a time, each root refilled from the last slot.
// A sift does at most one heap read and one compare a cycle: up reads and compares
// the parent; down reads each child that exists, then compares with the smaller.
// One request at a time; not ready while busy.
// Reset clears the clock, heap count and id-present bits; nothing is swept.
// ----------------------------------------------------------------------------
module min_heap_timer_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // timer_id [7:0], timeout_ms [27:8]
  input  logic [1:0]  s_axis_tuser,   // req_type [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // fired_id [7:0], next_delay_ms [27:8],
                                      // queue_empty [28]
  output logic [1:0]  m_axis_tuser,   // result_kind [1:0]
  output logic        m_axis_tlast    // last
);
  import mhtq_pkg::*;

  // input fields
  logic [ID_FW-1:0]  in_id;
  logic [TMO_FW-1:0] in_tmo;
  req_e              in_req;
  logic              in_xfer, out_xfer, id_ok;
  logic [ID_W-1:0]   in_idx;

  assign in_id   = s_axis_tdata[ID_FW-1:0];
  assign in_tmo  = s_axis_tdata[ID_FW+TMO_FW-1:ID_FW];
  assign in_req  = req_e'(s_axis_tuser);
  assign in_idx  = ID_W'(in_id);
  assign id_ok   = (int'(in_id) < ID_COUNT);

  // state
  state_e              state_q, state_d;
  time_t               now_q, now_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ID_COUNT-1:0] present_q, present_d;
  logic [ID_FW-1:0]    hid_q [HEAP_DEPTH];
  time_t               hdl_q [HEAP_DEPTH];

  logic [ID_FW-1:0]    cur_id_q, cur_id_d, ch_id_q, ch_id_d, fid_q, fid_d;
  time_t               cur_dl_q, cur_dl_d, ch_dl_q, ch_dl_d;
  logic [HEAP_AW-1:0]  pos_q, pos_d, start_q, start_d, ch_pos_q, ch_pos_d;
  logic [CNT_W-1:0]    n_q, n_d;
  kind_e               kind_q, kind_d;
  logic                last_q, last_d, tick_q, tick_d;
  logic                mreq_q, mreq_d;
  logic                cancel_q, cancel_d;

  // output register
  logic                 ov_q, ov_d;
  kind_e                okind_q, okind_d;
  logic [ID_FW-1:0]     ofid_q, ofid_d;
  logic [DELAY_FW-1:0]  odly_q, odly_d;
  logic                 oempty_q, oempty_d, olast_q, olast_d;

  // heap port
  logic [HEAP_AW-1:0]  rd_addr, wr_addr;
  logic                wr_en;
  logic [ID_FW-1:0]    wr_id, rd_id;
  time_t               wr_dl, rd_dl;

  assign rd_id = hid_q[rd_addr];
  assign rd_dl = hdl_q[rd_addr];

  // slot table
  logic                slot_we;
  logic [ID_W-1:0]     slot_waddr, slot_raddr;
  logic [HEAP_AW-1:0]  slot_wdata, slot_rdata;

  mhtq_ram #(
    .Width (HEAP_AW),
    .Depth (ID_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // shared compare unit
  time_t    alu_a, alu_b;
  alu_res_t alu;

  mhtq_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  // child and parent indexes
  logic [IDX_W-1:0]   child, child1;
  logic [HEAP_AW-1:0] parent;
  logic               down_end_up;

  assign child       = (IDX_W'(pos_q) << 1) + IDX_W'(1);
  assign child1      = IDX_W'(ch_pos_q) + IDX_W'(1);
  assign parent      = (pos_q - HEAP_AW'(1)) >> 1;
  assign down_end_up = (pos_q == start_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = ov_q && m_axis_tready;

  // cancel request remembered from the accepted transfer
  assign cancel_d = in_xfer ? (in_req == REQ_CANCEL) : cancel_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    cnt_d      = cnt_q;
    present_d  = present_q;
    cur_id_d   = cur_id_q;
    cur_dl_d   = cur_dl_q;
    ch_id_d    = ch_id_q;
    ch_dl_d    = ch_dl_q;
    ch_pos_d   = ch_pos_q;
    pos_d      = pos_q;
    start_d    = start_q;
    n_d        = n_q;
    kind_d     = kind_q;
    fid_d      = fid_q;
    last_d     = last_q;
    tick_d     = tick_q;
    mreq_d     = mreq_q;
    ov_d       = ov_q;
    okind_d    = okind_q;
    ofid_d     = ofid_q;
    odly_d     = odly_q;
    oempty_d   = oempty_q;
    olast_d    = olast_q;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = pos_q;
    wr_id      = cur_id_q;
    wr_dl      = cur_dl_q;
    slot_we    = 1'b0;
    slot_waddr = ID_W'(cur_id_q);
    slot_wdata = pos_q;
    slot_raddr = in_idx;
    alu_a      = cur_dl_q;
    alu_b      = ch_dl_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cur_id_d = in_id;
          cur_dl_d = now_q + TIME_WIDTH'(in_tmo);
          kind_d   = KIND_DONE;
          fid_d    = '0;
          last_d   = 1'b1;
          tick_d   = 1'b0;
          mreq_d   = (in_req == REQ_SET);
          n_d      = cnt_q;
          if (in_req == REQ_TICK) begin
            now_d   = now_q + TIME_WIDTH'(1);
            tick_d  = 1'b1;
            state_d = ST_TICK_CHK;
          end else if (!id_ok) begin
            kind_d  = KIND_UNKNOWN;
            state_d = ST_EMIT;
          end else if (in_req == REQ_SET && !present_q[in_idx]) begin
            if (int'(cnt_q) >= HEAP_DEPTH) begin
              kind_d  = KIND_FULL;
              state_d = ST_EMIT;
            end else begin
              // new timer enters at the bottom and sifts up
              present_d[in_idx] = 1'b1;
              pos_d             = HEAP_AW'(cnt_q);
              cnt_d             = cnt_q + CNT_W'(1);
              state_d           = ST_UP_P;
            end
          end else if (!present_q[in_idx]) begin
            kind_d  = KIND_UNKNOWN;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_LOOKUP;
          end
        end
      end

      ST_LOOKUP: begin
        pos_d   = slot_rdata;
        start_d = slot_rdata;
        if (!mreq_q && cancel_q) begin
          // cancel: remove the slot
          present_d[ID_W'(cur_id_q)] = 1'b0;
          cnt_d  = cnt_q - CNT_W'(1);
          n_d    = cnt_q - CNT_W'(1);
          kind_d = KIND_FIRED;
          fid_d  = cur_id_q;
          if (CNT_W'(slot_rdata) < cnt_q - CNT_W'(1)) begin
            state_d = ST_RM_LAST;
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          state_d = ST_DN_C;
        end
      end

      ST_RM_LAST: begin
        // last element refills the hole
        rd_addr  = HEAP_AW'(n_q);
        cur_id_d = rd_id;
        cur_dl_d = rd_dl;
        state_d  = ST_DN_C;
      end

      ST_DN_C: begin
        rd_addr = child[HEAP_AW-1:0];
        if (child >= IDX_W'(n_q)) begin
          state_d = down_end_up ? ST_UP_P : ST_PLACE;
        end else begin
          ch_id_d  = rd_id;
          ch_dl_d  = rd_dl;
          ch_pos_d = child[HEAP_AW-1:0];
          state_d  = (child + IDX_W'(1) < IDX_W'(n_q)) ? ST_DN_C1 : ST_DN_CMP;
        end
      end

      ST_DN_C1: begin
        rd_addr = child1[HEAP_AW-1:0];
        alu_a   = rd_dl;
        alu_b   = ch_dl_q;
        if (alu.lt) begin
          ch_id_d  = rd_id;
          ch_dl_d  = rd_dl;
          ch_pos_d = child1[HEAP_AW-1:0];
        end
        state_d = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        alu_a = cur_dl_q;
        alu_b = ch_dl_q;
        if (alu.lt) begin
          state_d = down_end_up ? ST_UP_P : ST_PLACE;
        end else begin
          // child moves up into the hole
          wr_en      = 1'b1;
          wr_id      = ch_id_q;
          wr_dl      = ch_dl_q;
          slot_we    = 1'b1;
          slot_waddr = ID_W'(ch_id_q);
          pos_d      = ch_pos_q;
          state_d    = ST_DN_C;
        end
      end

      ST_UP_P: begin
        rd_addr = parent;
        alu_a   = rd_dl;
        alu_b   = cur_dl_q;
        if (pos_q == '0 || alu.lt) begin
          state_d = ST_PLACE;
        end else begin
          // parent moves down into the hole
          wr_en      = 1'b1;
          wr_id      = rd_id;
          wr_dl      = rd_dl;
          slot_we    = 1'b1;
          slot_waddr = ID_W'(rd_id);
          pos_d      = parent;
        end
      end

      ST_PLACE: begin
        wr_en   = 1'b1;
        slot_we = 1'b1;
        state_d = ST_EMIT;
      end

      ST_TICK_CHK: begin
        rd_addr = '0;
        alu_a   = now_q;
        alu_b   = rd_dl;
        if (cnt_q != '0 && !alu.lt) begin
          // root is due: fire and remove it
          present_d[ID_W'(rd_id)] = 1'b0;
          cnt_d   = cnt_q - CNT_W'(1);
          n_d     = cnt_q - CNT_W'(1);
          pos_d   = '0;
          start_d = '0;
          kind_d  = KIND_FIRED;
          fid_d   = rd_id;
          last_d  = 1'b0;
          state_d = (cnt_q > CNT_W'(1)) ? ST_RM_LAST : ST_EMIT;
        end else begin
          kind_d  = KIND_DONE;
          fid_d   = '0;
          last_d  = 1'b1;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        rd_addr  = '0;
        alu_a    = rd_dl;
        alu_b    = now_q;
        ov_d     = 1'b1;
        okind_d  = kind_q;
        ofid_d   = fid_q;
        olast_d  = last_q;
        oempty_d = (cnt_q == '0);
        if (cnt_q == '0 || alu.lt) begin
          odly_d = '0;
        end else if (64'(alu.diff) > 64'(DELAY_MAX)) begin
          odly_d = DELAY_MAX;
        end else begin
          odly_d = DELAY_FW'(alu.diff);
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (out_xfer) begin
          ov_d    = 1'b0;
          state_d = (tick_q && !last_q) ? ST_TICK_CHK : ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      now_q     <= '0;
      cnt_q     <= '0;
      present_q <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      cnt_q     <= cnt_d;
      present_q <= present_d;
      ov_q      <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_id_q <= cur_id_d;
    cur_dl_q <= cur_dl_d;
    ch_id_q  <= ch_id_d;
    ch_dl_q  <= ch_dl_d;
    ch_pos_q <= ch_pos_d;
    pos_q    <= pos_d;
    start_q  <= start_d;
    n_q      <= n_d;
    kind_q   <= kind_d;
    fid_q    <= fid_d;
    last_q   <= last_d;
    tick_q   <= tick_d;
    mreq_q   <= mreq_d;
    cancel_q <= cancel_d;
    okind_q  <= okind_d;
    ofid_q   <= ofid_d;
    odly_q   <= odly_d;
    oempty_q <= oempty_d;
    olast_q  <= olast_d;
    if (wr_en) begin
      hid_q[wr_addr] <= wr_id;
      hdl_q[wr_addr] <= wr_dl;
    end
  end

  // result port
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {3'b000, oempty_q, odly_q, ofid_q};

endmodule

// ----- verif/min_heap_timer_queue_checker.sv -----
// ----------------------------------------------------------------------------
// min_heap_timer_queue_checker
// Watches both stream channels, keeps its own timer heap and clock, predicts
// every result of each request transfer and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_heap_timer_queue_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o,
  output int          fired_count_o
);
  import mhtq_pkg::*;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          fid;
    logic [DELAY_FW-1:0] delay;
    logic                empty;
    logic                last;
  } timer_result_t;

  // predictor state
  time_t       clock_ms;
  logic [7:0]  slot_id   [HEAP_DEPTH];
  time_t       slot_dl   [HEAP_DEPTH];
  int          id_slot   [ID_COUNT];
  bit          id_armed  [ID_COUNT];
  int          live_count;

  timer_result_t expected_results[$];

  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    logic [7:0] tid;
    time_t      tdl;
    tid = slot_id[a]; tdl = slot_dl[a];
    slot_id[a] = slot_id[b]; slot_dl[a] = slot_dl[b];
    slot_id[b] = tid; slot_dl[b] = tdl;
    id_slot[slot_id[a]] = a;
    id_slot[slot_id[b]] = b;
  endfunction

  function automatic void bubble_up(input int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (slot_dl[p] < slot_dl[i]) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic bit bubble_down(input int start, input int n);
    int i, c;
    i = start;
    c = 2 * i + 1;
    while (c < n) begin
      if (c + 1 < n && slot_dl[c+1] < slot_dl[c]) c++;
      if (slot_dl[i] < slot_dl[c]) break;
      swap_slots(i, c);
      i = c;
      c = 2 * i + 1;
    end
    return i > start;
  endfunction

  function automatic void drop_slot(input int i);
    int n;
    logic [7:0] gone;
    n = live_count - 1;
    gone = slot_id[i];
    if (i < n) begin
      swap_slots(i, n);
      if (!bubble_down(i, n)) bubble_up(i);
    end
    id_armed[gone] = 0;
    live_count = n;
  endfunction

  function automatic void push_result(input kind_e kind, input logic [7:0] fid);
    timer_result_t r;
    time_t d;
    r.kind  = kind;
    r.fid   = fid;
    r.delay = '0;
    if (live_count > 0 && slot_dl[0] > clock_ms) begin
      d = slot_dl[0] - clock_ms;
      r.delay = (d > time_t'(DELAY_MAX)) ? DELAY_MAX : d[DELAY_FW-1:0];
    end
    r.empty = (live_count == 0);
    r.last  = 0;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // work out all results of one request
  function automatic void predict_request(input req_e req, input logic [7:0] id,
                                          input logic [TMO_FW-1:0] tmo);
    time_t dl;
    int    s;
    dl = clock_ms + time_t'(tmo);
    if (req == REQ_TICK) begin
      clock_ms = clock_ms + 1;
      while (live_count > 0 && slot_dl[0] <= clock_ms) begin
        s = slot_id[0];
        drop_slot(0);
        push_result(KIND_FIRED, 8'(s));
      end
      push_result(KIND_DONE, 8'd0);
    end else if (int'(id) >= ID_COUNT) begin
      push_result(KIND_UNKNOWN, 8'd0);
    end else if (req == REQ_SET) begin
      if (id_armed[id]) begin
        s = id_slot[id];
        slot_dl[s] = dl;
        if (!bubble_down(s, live_count)) bubble_up(s);
        push_result(KIND_DONE, 8'd0);
      end else if (live_count >= HEAP_DEPTH) begin
        push_result(KIND_FULL, 8'd0);
      end else begin
        s = live_count;
        slot_id[s] = id;
        slot_dl[s] = dl;
        id_slot[id] = s;
        id_armed[id] = 1;
        live_count = s + 1;
        bubble_up(s);
        push_result(KIND_DONE, 8'd0);
      end
    end else if (!id_armed[id]) begin
      push_result(KIND_UNKNOWN, 8'd0);
    end else if (req == REQ_ADJUST) begin
      s = id_slot[id];
      slot_dl[s] = dl;
      if (!bubble_down(s, live_count)) bubble_up(s);
      push_result(KIND_DONE, 8'd0);
    end else begin
      drop_slot(id_slot[id]);
      push_result(KIND_FIRED, id);
    end
    expected_results[$].last = 1;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t exp_r;
    if (!rst_ni) begin
      clock_ms = '0;
      live_count = 0;
      fail_count_o = 0;
      fired_count_o = 0;
      foreach (id_armed[i]) id_armed[i] = 0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_request(req_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[27:8]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.kind == KIND_FIRED) fired_count_o++;
          if (m_axis_tuser != exp_r.kind)
            report_mismatch($sformatf("kind %0d exp %0d", m_axis_tuser, exp_r.kind));
          if (m_axis_tdata[7:0] != exp_r.fid)
            report_mismatch($sformatf("fired_id %0d exp %0d", m_axis_tdata[7:0], exp_r.fid));
          if (m_axis_tdata[27:8] != exp_r.delay)
            report_mismatch($sformatf("delay %0d exp %0d", m_axis_tdata[27:8], exp_r.delay));
          if (m_axis_tdata[28] != exp_r.empty)
            report_mismatch($sformatf("queue_empty %0b exp %0b", m_axis_tdata[28], exp_r.empty));
          if (m_axis_tdata[31:29] != 3'b0)
            report_mismatch("nonzero pad bits");
          if (m_axis_tlast != exp_r.last)
            report_mismatch($sformatf("last %0b exp %0b", m_axis_tlast, exp_r.last));
        end
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives set, adjust, cancel and tick requests into the timer queue with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mhtq_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  int          fired_count;
  int          request_count;

  min_heap_timer_queue u_top (.*);

  min_heap_timer_queue_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending), .fired_count_o(fired_count)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request transfer, with a random gap first
  task automatic send_request(input req_e req, input logic [7:0] id,
                              input logic [TMO_FW-1:0] tmo);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {4'b0, tmo, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    request_count++;
    @(negedge clk_i);
  endtask

  // output stalls
  initial begin
    int gap;
    m_axis_tready = 0;
    @(negedge clk_i);
    forever begin
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      gap = gap_len();
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("testbench failed");
    $finish;
  end

  initial begin
    int   wait_cycles;
    req_e req;
    logic [7:0] id;
    logic [TMO_FW-1:0] tmo;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_TICK;
    request_count = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: empty queue cases, extremes, ties, full heap
    send_request(REQ_TICK, 8'd0, '0);
    send_request(REQ_ADJUST, 8'd5, 20'd3);
    send_request(REQ_CANCEL, 8'd255, '0);
    send_request(REQ_SET, 8'd0, 20'd0);
    send_request(REQ_SET, 8'd255, 20'hFFFFF);
    send_request(REQ_SET, 8'd7, 20'd2);
    send_request(REQ_SET, 8'd8, 20'd2);
    send_request(REQ_SET, 8'd7, 20'd5);
    send_request(REQ_ADJUST, 8'd255, 20'd1);
    send_request(REQ_TICK, 8'hAA, 20'h55555);
    send_request(REQ_TICK, 8'd0, '0);
    send_request(REQ_CANCEL, 8'd8, '0);
    send_request(REQ_CANCEL, 8'd8, '0);
    for (int i = 0; i < 33; i++)
      send_request(REQ_SET, 8'(8'd100 + i), 20'(3 + (i % 4)));
    repeat (6) send_request(REQ_TICK, 8'd0, '0);

    // random: mostly well-formed timer traffic on a small id pool
    for (int n = 0; n < 380; n++) begin
      int r;
      r = $urandom_range(0, 99);
      req = (r < 35) ? REQ_SET : (r < 50) ? REQ_ADJUST : (r < 62) ? REQ_CANCEL : REQ_TICK;
      id  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 39)) : 8'($urandom);
      case ($urandom_range(0, 4))
        0:       tmo = 20'($urandom);
        1:       tmo = 20'hFFFFF - 20'($urandom_range(0, 3));
        default: tmo = 20'($urandom_range(0, 12));
      endcase
      send_request(req, id, tmo);
    end
    // closing tick requests; timers with long timeouts stay armed
    repeat (20) send_request(REQ_TICK, 8'd0, '0);
    s_axis_tvalid <= 0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (60) @(negedge clk_i);
    $display("covered %0d requests, %0d timer fires, %0d results still owed",
             request_count, fired_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
